@@ rtl/tesp_pkg.sv @@
// ============================================================================
// tesp_pkg
// Shared types and constants for the tree entry stream parser.
// ============================================================================
package tesp_pkg;

    localparam int HASH_LEN_DEF   = 20;
    localparam int COUNT_BITS_DEF = 16;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int ETYPE_W = 2;
    localparam int PERM_W  = 9;
    localparam int ERR_W   = 2;
    localparam int CNT_W   = 16;
    localparam int MODE_W  = 16;

    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_SEVEN = 8'h37;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

    localparam logic [3:0] FMT_FILE    = 4'b1000;
    localparam logic [3:0] FMT_DIR     = 4'b0100;
    localparam logic [3:0] FMT_SYMLINK = 4'b1010;

    typedef enum logic [KIND_W-1:0] {
        K_NAME   = 3'd0,
        K_HASH   = 3'd1,
        K_ENTRY  = 3'd2,
        K_OBJECT = 3'd3,
        K_ERROR  = 3'd4
    } kind_t;

    typedef enum logic [ERR_W-1:0] {
        E_DIGIT = 2'd0,
        E_TRUNC = 2'd1,
        E_EMPTY = 2'd2,
        E_TYPE  = 2'd3
    } err_t;

    typedef enum logic [ETYPE_W-1:0] {
        T_FILE    = 2'd0,
        T_DIR     = 2'd1,
        T_SYMLINK = 2'd2
    } etype_t;

    // Everything one input byte produces, in output order:
    // data word, then entry-done or error, then object-done.
    typedef struct packed {
        logic              data_v;
        logic              data_hash;
        logic [BYTE_W-1:0] data_byte;
        logic              mid_v;
        logic              mid_err;
        err_t              err;
        etype_t            etype;
        logic [PERM_W-1:0] perm;
        logic              obj_v;
    } op_t;

endpackage

@@ rtl/tesp_front.sv @@
// ============================================================================
// tesp_front
// Byte parser: tracks mode, name and hash phases, builds up to one op per byte.
// ============================================================================
module tesp_front #(
    parameter int HASH_LEN = tesp_pkg::HASH_LEN_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [tesp_pkg::BYTE_W-1:0] in_byte,
    input  logic                       end_of_object,
    output logic                       op_push,
    output tesp_pkg::op_t              op
);
    import tesp_pkg::*;

    localparam int HCNT_W = $clog2(HASH_LEN + 1);

    typedef enum logic [5:0] {
        ST_MODE_FIRST = 6'b000001,
        ST_MODE_MORE  = 6'b000010,
        ST_NAME_FIRST = 6'b000100,
        ST_NAME_MORE  = 6'b001000,
        ST_HASH       = 6'b010000,
        ST_DROP       = 6'b100000
    } state_t;

    state_t              state_reg, state_next, state_parse;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [HCNT_W-1:0]   hcnt_reg, hcnt_next, hcnt_inc;
    logic                digit;
    logic [3:0]          fmt;

    always_comb
    begin
        digit       = in_byte inside {[CH_ZERO:CH_SEVEN]};
        fmt         = mode_reg[MODE_W-1:MODE_W-4];
        hcnt_inc    = HCNT_W'(hcnt_reg + 1'b1);
        op          = '0;
        state_parse = state_reg;
        mode_next   = mode_reg;
        hcnt_next   = hcnt_reg;
        case (state_reg)
            ST_MODE_FIRST:
            begin
                if (!digit)
                begin
                    op.mid_v    = 1'b1;
                    op.mid_err  = 1'b1;
                    op.err      = E_DIGIT;
                    state_parse = ST_DROP;
                end
                else
                begin
                    mode_next   = MODE_W'(in_byte[2:0]);
                    state_parse = ST_MODE_MORE;
                end
            end
            ST_MODE_MORE:
            begin
                if (in_byte == CH_SPACE)
                begin
                    state_parse = ST_NAME_FIRST;
                end
                else if (!digit)
                begin
                    op.mid_v    = 1'b1;
                    op.mid_err  = 1'b1;
                    op.err      = E_DIGIT;
                    state_parse = ST_DROP;
                end
                else
                begin
                    mode_next = {mode_reg[MODE_W-4:0], in_byte[2:0]};
                end
            end
            ST_NAME_FIRST:
            begin
                if (in_byte == CH_NUL)
                begin
                    op.mid_v    = 1'b1;
                    op.mid_err  = 1'b1;
                    op.err      = E_EMPTY;
                    state_parse = ST_DROP;
                end
                else
                begin
                    op.data_v    = 1'b1;
                    op.data_byte = in_byte;
                    state_parse  = ST_NAME_MORE;
                end
            end
            ST_NAME_MORE:
            begin
                if (in_byte == CH_NUL)
                begin
                    state_parse = ST_HASH;
                    hcnt_next   = '0;
                end
                else
                begin
                    op.data_v    = 1'b1;
                    op.data_byte = in_byte;
                end
            end
            ST_HASH:
            begin
                op.data_v    = 1'b1;
                op.data_hash = 1'b1;
                op.data_byte = in_byte;
                hcnt_next    = hcnt_inc;
                if (hcnt_inc == HCNT_W'(HASH_LEN))
                begin
                    op.mid_v = 1'b1;
                    op.perm  = mode_reg[PERM_W-1:0];
                    if (fmt == FMT_FILE || fmt == FMT_DIR || fmt == FMT_SYMLINK)
                    begin
                        op.etype    = (fmt == FMT_FILE) ? T_FILE :
                                      (fmt == FMT_DIR)  ? T_DIR : T_SYMLINK;
                        state_parse = ST_MODE_FIRST;
                        mode_next   = '0;
                        hcnt_next   = '0;
                    end
                    else
                    begin
                        op.mid_err  = 1'b1;
                        op.err      = E_TYPE;
                        op.perm     = '0;
                        state_parse = ST_DROP;
                    end
                end
            end
            ST_DROP:
            begin
                state_parse = ST_DROP;
            end
            default:
            begin
                state_parse = ST_DROP;
            end
        endcase

        state_next = state_parse;
        if (end_of_object)
        begin
            // truncated unless the byte closed an entry or an error is pending
            if (state_parse != ST_DROP &&
                (state_parse != ST_MODE_FIRST || !(op.data_v || op.mid_v)))
            begin
                op.mid_v   = 1'b1;
                op.mid_err = 1'b1;
                op.err     = E_TRUNC;
                op.etype   = T_FILE;
                op.perm    = '0;
            end
            op.obj_v   = 1'b1;
            state_next = ST_MODE_FIRST;
            mode_next  = '0;
            hcnt_next  = '0;
        end
        op_push = in_valid && (op.data_v || op.mid_v || op.obj_v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_MODE_FIRST;
            mode_reg  <= '0;
            hcnt_reg  <= '0;
        end
        else if (in_valid)
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            hcnt_reg  <= hcnt_next;
        end
    end

endmodule

@@ rtl/tesp_queue.sv @@
// ============================================================================
// tesp_queue
// Short op queue between parser and result generator.
// ============================================================================
module tesp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tesp_pkg::op_t push_op,
    output logic          full,
    input  logic          pop,
    output tesp_pkg::op_t head_op,
    output logic          empty
);
    import tesp_pkg::*;

    op_t               slot_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_push, do_pop;

    assign full    = (cnt_reg == QCNT_W'(Q_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head_op = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= QPTR_W'(wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= QPTR_W'(rd_ptr_reg + 1'b1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= QCNT_W'(cnt_reg + 1'b1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= QCNT_W'(cnt_reg - 1'b1);
            end
        end
    end

endmodule

@@ rtl/tesp_back.sv @@
// ============================================================================
// tesp_back
// Result generator: expands ops into words, keeps saturating counts.
// ============================================================================
module tesp_back #(
    parameter int COUNT_BITS = tesp_pkg::COUNT_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tesp_pkg::op_t                head_op,
    input  logic                         q_empty,
    output logic                         q_pop,
    output logic                         empty,
    input  logic                         pop,
    output logic [tesp_pkg::KIND_W-1:0]  kind,
    output logic [tesp_pkg::BYTE_W-1:0]  data_byte,
    output logic [tesp_pkg::ETYPE_W-1:0] entry_type,
    output logic [tesp_pkg::PERM_W-1:0]  permissions,
    output logic                         has_permissions,
    output logic [tesp_pkg::ERR_W-1:0]   error_code,
    output logic [tesp_pkg::CNT_W-1:0]   entry_count,
    output logic [tesp_pkg::CNT_W-1:0]   subdir_count,
    output logic                         last_of_run
);
    import tesp_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic                  out_valid_reg;
    kind_t                 kind_reg, kind_next;
    logic [BYTE_W-1:0]     byte_reg, byte_next;
    logic [ETYPE_W-1:0]    etype_reg, etype_next;
    logic [PERM_W-1:0]     perm_reg, perm_next;
    logic                  hasp_reg, hasp_next;
    logic [ERR_W-1:0]      err_reg, err_next;
    logic [CNT_W-1:0]      ecnt_out_reg, ecnt_out_next;
    logic [CNT_W-1:0]      scnt_out_reg, scnt_out_next;
    logic                  last_reg, last_next;
    logic                  data_sent_reg, data_sent_next;
    logic                  mid_sent_reg, mid_sent_next;
    logic [COUNT_BITS-1:0] ecnt_reg, ecnt_next;
    logic [COUNT_BITS-1:0] scnt_reg, scnt_next;
    logic                  load, sel_data, sel_mid;

    assign empty           = !out_valid_reg;
    assign kind            = kind_reg;
    assign data_byte       = byte_reg;
    assign entry_type      = etype_reg;
    assign permissions     = perm_reg;
    assign has_permissions = hasp_reg;
    assign error_code      = err_reg;
    assign entry_count     = ecnt_out_reg;
    assign subdir_count    = scnt_out_reg;
    assign last_of_run     = last_reg;

    always_comb
    begin
        load      = !q_empty && (!out_valid_reg || pop);
        sel_data  = head_op.data_v && !data_sent_reg;
        sel_mid   = !sel_data && head_op.mid_v && !mid_sent_reg;
        ecnt_next = ecnt_reg;
        scnt_next = scnt_reg;
        kind_next = K_OBJECT;
        byte_next = '0;
        etype_next = '0;
        perm_next = '0;
        hasp_next = 1'b0;
        err_next  = '0;
        last_next = 1'b1;
        data_sent_next = data_sent_reg;
        mid_sent_next  = mid_sent_reg;
        if (sel_data)
        begin
            kind_next = head_op.data_hash ? K_HASH : K_NAME;
            byte_next = head_op.data_byte;
            last_next = !(head_op.mid_v || head_op.obj_v);
        end
        else if (sel_mid)
        begin
            last_next = !head_op.obj_v;
            if (head_op.mid_err)
            begin
                kind_next = K_ERROR;
                err_next  = head_op.err;
            end
            else
            begin
                kind_next  = K_ENTRY;
                etype_next = head_op.etype;
                perm_next  = head_op.perm;
                hasp_next  = (head_op.perm != '0);
                if (ecnt_reg != CNT_MAX)
                begin
                    ecnt_next = COUNT_BITS'(ecnt_reg + 1'b1);
                end
                if (head_op.etype == T_DIR && scnt_reg != CNT_MAX)
                begin
                    scnt_next = COUNT_BITS'(scnt_reg + 1'b1);
                end
            end
        end
        ecnt_out_next = CNT_W'(ecnt_next);
        scnt_out_next = CNT_W'(scnt_next);
        if (!sel_data && !sel_mid)
        begin
            ecnt_next = '0;
            scnt_next = '0;
        end
        if (last_next)
        begin
            data_sent_next = 1'b0;
            mid_sent_next  = 1'b0;
        end
        else if (sel_data)
        begin
            data_sent_next = 1'b1;
        end
        else
        begin
            mid_sent_next = 1'b1;
        end
        q_pop = load && last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            data_sent_reg <= 1'b0;
            mid_sent_reg  <= 1'b0;
            ecnt_reg      <= '0;
            scnt_reg      <= '0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
            data_sent_reg <= data_sent_next;
            mid_sent_reg  <= mid_sent_next;
            ecnt_reg      <= ecnt_next;
            scnt_reg      <= scnt_next;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg     <= kind_next;
            byte_reg     <= byte_next;
            etype_reg    <= etype_next;
            perm_reg     <= perm_next;
            hasp_reg     <= hasp_next;
            err_reg      <= err_next;
            ecnt_out_reg <= ecnt_out_next;
            scnt_out_reg <= scnt_out_next;
            last_reg     <= last_next;
        end
    end

endmodule

@@ rtl/tree_entry_stream_parser.sv @@
// ============================================================================
// tree_entry_stream_parser
// Streaming tree object parser: passes name and hash bytes, reports entry
// type, permissions and counts, flags errors.
// ============================================================================
//  channel | direction | handshake        | words
//  input   | in        | push / full      | in_byte, end_of_object
//  result  | out       | empty / pop      | kind .. last_of_run
//
//  One input byte per cycle is accepted while the two-entry op queue has room.
//  A byte gives zero to three result words, queued as one op and registered
//  onto the result ports; the result side emits one word a cycle while the
//  receiver pops, so an op of several words stays at the queue head until its last word loads.
//  Reset clears parser state, queue and counts; no clearing pass.
// ============================================================================
module tree_entry_stream_parser #(
    parameter int HASH_LEN   = tesp_pkg::HASH_LEN_DEF,
    parameter int COUNT_BITS = tesp_pkg::COUNT_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [tesp_pkg::BYTE_W-1:0]  in_byte,
    input  logic                         end_of_object,
    output logic                         empty,
    input  logic                         pop,
    output logic [tesp_pkg::KIND_W-1:0]  kind,
    output logic [tesp_pkg::BYTE_W-1:0]  data_byte,
    output logic [tesp_pkg::ETYPE_W-1:0] entry_type,
    output logic [tesp_pkg::PERM_W-1:0]  permissions,
    output logic                         has_permissions,
    output logic [tesp_pkg::ERR_W-1:0]   error_code,
    output logic [tesp_pkg::CNT_W-1:0]   entry_count,
    output logic [tesp_pkg::CNT_W-1:0]   subdir_count,
    output logic                         last_of_run
);
    import tesp_pkg::*;

    op_t  front_op, head_op;
    logic op_push, q_empty, q_pop, accept;

    assign accept = push && !full;

    tesp_front #(
        .HASH_LEN (HASH_LEN)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (accept),
        .in_byte       (in_byte),
        .end_of_object (end_of_object),
        .op_push       (op_push),
        .op            (front_op)
    );

    tesp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (op_push),
        .push_op (front_op),
        .full    (full),
        .pop     (q_pop),
        .head_op (head_op),
        .empty   (q_empty)
    );

    tesp_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_op         (head_op),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .empty           (empty),
        .pop             (pop),
        .kind            (kind),
        .data_byte       (data_byte),
        .entry_type      (entry_type),
        .permissions     (permissions),
        .has_permissions (has_permissions),
        .error_code      (error_code),
        .entry_count     (entry_count),
        .subdir_count    (subdir_count),
        .last_of_run     (last_of_run)
    );

endmodule

@@ rtl/tesp_checker.sv @@
// ============================================================================
// tesp_checker
// Port-level checks on the result stream of the parser.
// ============================================================================
module tesp_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         empty,
    input logic                         pop,
    input logic [tesp_pkg::KIND_W-1:0]  kind,
    input logic [tesp_pkg::BYTE_W-1:0]  data_byte,
    input logic [tesp_pkg::PERM_W-1:0]  permissions,
    input logic                         has_permissions,
    input logic                         last_of_run
);
    import tesp_pkg::*;

    a_obj_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == K_OBJECT) |-> last_of_run)
        else $error("object done is not last word of its byte");

    a_name_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == K_NAME) |-> (data_byte != '0))
        else $error("name word carries terminator");

    a_perm_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == K_ENTRY) |-> (has_permissions == (permissions != '0)))
        else $error("permission flag mismatch");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(kind) && $stable(last_of_run)))
        else $error("stalled word changed");

endmodule

bind tree_entry_stream_parser tesp_checker u_tesp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .empty           (empty),
    .pop             (pop),
    .kind            (kind),
    .data_byte       (data_byte),
    .permissions     (permissions),
    .has_permissions (has_permissions),
    .last_of_run     (last_of_run)
);

@@ bench/tb_tree_entry_stream_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tree_entry_stream_parser
// Self-checking bench for the tree entry stream parser. Feeds short
// hand-built objects for the corner cases, then random objects that are
// mostly well formed (file, directory, symlink, unsupported and zero-perm
// modes) with some truncated, corrupted or noise objects mixed in. Each
// accepted byte is run through a behavioral predictor, and every result
// word is compared field by field. Runs under several idle and stall mixes,
// including a long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_tree_entry_stream_parser;
    import tesp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASE_BYTES  = 10;
    localparam int DRAIN_CYCLES = 20;

    typedef enum {
        P_MODE_FIRST,
        P_MODE_MORE,
        P_NAME_FIRST,
        P_NAME_MORE,
        P_HASH,
        P_DROP
    } parse_phase_t;

    typedef enum {
        FLAW_NONE,
        FLAW_TRUNC,
        FLAW_DIGIT,
        FLAW_EMPTY,
        FLAW_NOISE
    } flaw_t;

    typedef struct {
        kind_t             kind;
        logic [BYTE_W-1:0] data;
        etype_t            etype;
        logic [PERM_W-1:0] perm;
        logic              hasp;
        err_t              err;
        logic [CNT_W-1:0]  ecnt;
        logic [CNT_W-1:0]  scnt;
        logic              run_end;
    } word_t;

    class tree_stream_scoreboard;
        word_t              pending_words [$];
        parse_phase_t       ph;
        logic [31:0]        mode_acc;
        int                 hash_cnt;
        longint unsigned    entries;
        longint unsigned    subdirs;
        bit                 err_seen;
        int                 mismatches;
        int                 words_checked;
        int                 entries_checked;
        int                 errors_checked;
        int                 objects_checked;

        function new();
            clear();
            mismatches      = 0;
            words_checked   = 0;
            entries_checked = 0;
            errors_checked  = 0;
            objects_checked = 0;
        endfunction

        function void clear();
            ph       = P_MODE_FIRST;
            mode_acc = '0;
            hash_cnt = 0;
            entries  = 0;
            subdirs  = 0;
            err_seen = 1'b0;
        endfunction

        function void put(kind_t k, logic [BYTE_W-1:0] d = '0, etype_t t = T_FILE,
                          logic [PERM_W-1:0] p = '0, err_t e = E_DIGIT);
            word_t w;
            w.kind    = k;
            w.data    = d;
            w.etype   = t;
            w.perm    = p;
            w.hasp    = (k == K_ENTRY) && (p != '0);
            w.err     = e;
            w.ecnt    = entries[CNT_W-1:0];
            w.scnt    = subdirs[CNT_W-1:0];
            w.run_end = 1'b0;
            pending_words.push_back(w);
        endfunction

        function void raise_error(err_t e);
            put(K_ERROR, '0, T_FILE, '0, e);
            err_seen = 1'b1;
            ph       = P_DROP;
        endfunction

        function void close_entry();
            longint unsigned cnt_max;
            etype_t          t;
            cnt_max = (64'd1 << COUNT_BITS_DEF) - 1;
            if (mode_acc[15:12] == FMT_FILE)
                t = T_FILE;
            else if (mode_acc[15:12] == FMT_DIR)
                t = T_DIR;
            else if (mode_acc[15:12] == FMT_SYMLINK)
                t = T_SYMLINK;
            else
            begin
                raise_error(E_TYPE);
                return;
            end
            if (entries < cnt_max)
                entries++;
            if (t == T_DIR && subdirs < cnt_max)
                subdirs++;
            put(K_ENTRY, '0, t, mode_acc[PERM_W-1:0]);
            ph       = P_MODE_FIRST;
            mode_acc = '0;
            hash_cnt = 0;
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b, logic eoo);
            int first;
            bit is_oct;
            first  = pending_words.size();
            is_oct = (b >= CH_ZERO) && (b <= CH_SEVEN);
            case (ph)
                P_MODE_FIRST:
                    if (!is_oct)
                        raise_error(E_DIGIT);
                    else
                    begin
                        mode_acc = 32'(b - CH_ZERO);
                        ph       = P_MODE_MORE;
                    end
                P_MODE_MORE:
                    if (b == CH_SPACE)
                        ph = P_NAME_FIRST;
                    else if (!is_oct)
                        raise_error(E_DIGIT);
                    else
                        mode_acc = (mode_acc << 3) + 32'(b - CH_ZERO);
                P_NAME_FIRST:
                    if (b == CH_NUL)
                        raise_error(E_EMPTY);
                    else
                    begin
                        put(K_NAME, b);
                        ph = P_NAME_MORE;
                    end
                P_NAME_MORE:
                    if (b == CH_NUL)
                    begin
                        ph       = P_HASH;
                        hash_cnt = 0;
                    end
                    else
                        put(K_NAME, b);
                P_HASH:
                begin
                    put(K_HASH, b);
                    hash_cnt++;
                    if (hash_cnt >= HASH_LEN_DEF)
                        close_entry();
                end
                default:
                    ph = P_DROP;
            endcase
            if (eoo)
            begin
                if (!err_seen && (ph != P_MODE_FIRST || pending_words.size() == first))
                    raise_error(E_TRUNC);
                put(K_OBJECT);
                clear();
            end
            if (pending_words.size() > first)
                pending_words[pending_words.size() - 1].run_end = 1'b1;
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task cmp(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("word %0d %s: got %0h expected %0h",
                                 words_checked, name, got, want));
        endtask

        task check_word(word_t got);
            word_t want;
            if (pending_words.size() == 0)
            begin
                report($sformatf("word %0d arrived with nothing expected (kind %0d)",
                                 words_checked, got.kind));
                words_checked++;
                return;
            end
            want = pending_words.pop_front();
            cmp("kind", got.kind, want.kind);
            cmp("data_byte", got.data, want.data);
            cmp("entry_type", got.etype, want.etype);
            cmp("permissions", got.perm, want.perm);
            cmp("has_permissions", got.hasp, want.hasp);
            cmp("error_code", got.err, want.err);
            cmp("entry_count", got.ecnt, want.ecnt);
            cmp("subdir_count", got.scnt, want.scnt);
            cmp("last_of_run", got.run_end, want.run_end);
            words_checked++;
            if (want.kind == K_ENTRY)
                entries_checked++;
            if (want.kind == K_ERROR)
                errors_checked++;
            if (want.kind == K_OBJECT)
                objects_checked++;
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    logic [BYTE_W-1:0]   in_byte;
    logic                end_of_object;
    logic                empty;
    logic                pop;
    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   data_byte;
    logic [ETYPE_W-1:0]  entry_type;
    logic [PERM_W-1:0]   permissions;
    logic                has_permissions;
    logic [ERR_W-1:0]    error_code;
    logic [CNT_W-1:0]    entry_count;
    logic [CNT_W-1:0]    subdir_count;
    logic                last_of_run;

    tree_stream_scoreboard sb;
    logic [BYTE_W-1:0]     obj_q [$];
    word_t                 observed;
    int                    send_idle_pct;
    int                    recv_stall_pct;
    int                    bytes_sent;
    int                    entry_sel;
    int                    cycle_count;
    bit                    hold_req;
    bit                    hold_on;
    int                    idle_by_phase  [4] = '{0, 74, 0, 26};
    int                    stall_by_phase [4] = '{0, 0, 74, 26};

    tree_entry_stream_parser u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .in_byte         (in_byte),
        .end_of_object   (end_of_object),
        .empty           (empty),
        .pop             (pop),
        .kind            (kind),
        .data_byte       (data_byte),
        .entry_type      (entry_type),
        .permissions     (permissions),
        .has_permissions (has_permissions),
        .error_code      (error_code),
        .entry_count     (entry_count),
        .subdir_count    (subdir_count),
        .last_of_run     (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            observed.kind    = kind_t'(kind);
            observed.data    = data_byte;
            observed.etype   = etype_t'(entry_type);
            observed.perm    = permissions;
            observed.hasp    = has_permissions;
            observed.err     = err_t'(error_code);
            observed.ecnt    = entry_count;
            observed.scnt    = subdir_count;
            observed.run_end = last_of_run;
            sb.check_word(observed);
        end
    end

    // result side: random stalls plus the long hold-off
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            pop <= rst_n && !hold_on && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        hold_on = 1'b0;
        wait (hold_req);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
    end

    function automatic logic [BYTE_W-1:0] oct_char(int d);
        return CH_ZERO + BYTE_W'(d);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            obj_q.push_back(s[i]);
    endfunction

    function automatic void add_perm_digits();
        repeat (3) obj_q.push_back(oct_char($urandom_range(7)));
    endfunction

    // one entry: mode digits, space, optional name, terminator, hash
    function automatic void add_entry(bit no_name, bit bad_mode);
        int                mode_start;
        int                pos;
        logic [BYTE_W-1:0] junk;
        mode_start = obj_q.size();
        if ($urandom_range(5) == 0)
            repeat ($urandom_range(1, 8)) obj_q.push_back(oct_char($urandom_range(7)));
        case (entry_sel % 5)
            0:
            begin
                add_text("100");
                add_perm_digits();
            end
            1:
            begin
                add_text("40");
                if ($urandom_range(1) == 0)
                    add_text("000");
                else
                    add_perm_digits();
            end
            2:
            begin
                add_text("120");
                add_perm_digits();
            end
            3:
                if ($urandom_range(1) == 0)
                    add_text("160000");
                else
                    repeat (6) obj_q.push_back(oct_char($urandom_range(7)));
            default:
                add_text("100000");
        endcase
        entry_sel++;
        if (bad_mode)
        begin
            pos = $urandom_range(mode_start, obj_q.size() - 1);
            do
                junk = BYTE_W'($urandom_range(255));
            while ((junk >= CH_ZERO && junk <= CH_SEVEN) || junk == CH_SPACE);
            obj_q[pos] = junk;
        end
        obj_q.push_back(CH_SPACE);
        if (!no_name)
            repeat ($urandom_range(1, 3)) obj_q.push_back(BYTE_W'($urandom_range(1, 255)));
        obj_q.push_back(CH_NUL);
        repeat (HASH_LEN_DEF) obj_q.push_back(BYTE_W'($urandom));
    endfunction

    task automatic send_byte(logic [BYTE_W-1:0] b, logic eoo);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push          <= 1'b1;
        in_byte       <= b;
        end_of_object <= eoo;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_byte(b, eoo);
        bytes_sent++;
    endtask

    task automatic send_queued();
        foreach (obj_q[i])
            send_byte(obj_q[i], i == obj_q.size() - 1);
    endtask

    task automatic send_object(int n_entries, flaw_t flaw);
        int bad_at;
        obj_q.delete();
        if (flaw == FLAW_NOISE)
            repeat ($urandom_range(1, 6)) obj_q.push_back(BYTE_W'($urandom));
        else
        begin
            bad_at = $urandom_range(n_entries - 1);
            for (int i = 0; i < n_entries; i++)
                add_entry(flaw == FLAW_EMPTY && i == bad_at, flaw == FLAW_DIGIT && i == bad_at);
        end
        if (flaw == FLAW_TRUNC)
            obj_q = obj_q[0:$urandom_range(obj_q.size() - 2)];
        send_queued();
    endtask

    initial
    begin
        int    start;
        flaw_t flaw;
        sb             = new();
        rst_n          = 1'b0;
        push           = 1'b0;
        in_byte        = '0;
        end_of_object  = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        bytes_sent     = 0;
        entry_sel      = 0;
        cycle_count    = 0;
        hold_req       = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // corner cases: digit bounds, truncation, empty name, dropped bytes
        obj_q = '{8'h2f};
        send_queued();
        obj_q = '{8'h38};
        send_queued();
        obj_q = '{CH_SEVEN};
        send_queued();
        obj_q = '{8'h31, 8'h38, 8'hff};
        send_queued();
        obj_q = '{CH_ZERO, CH_SPACE, CH_NUL, 8'h78};
        send_queued();
        obj_q = '{8'h31, CH_SPACE, CH_NUL};
        send_queued();
        obj_q = '{8'h34, CH_SPACE, 8'hff};
        send_queued();
        obj_q = '{8'h31, 8'h32, CH_SPACE, 8'h61, CH_NUL, 8'h00};
        send_queued();
        obj_q = '{CH_SPACE};
        send_queued();

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = idle_by_phase[p];
            recv_stall_pct = stall_by_phase[p];
            if (p == 0)
                hold_req = 1'b1;
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES)
            begin
                if ($urandom_range(99) < 70)
                    flaw = FLAW_NONE;
                else
                    flaw = flaw_t'($urandom_range(FLAW_TRUNC, FLAW_NOISE));
                send_object($urandom_range(1, 2), flaw);
            end
        end

        @(negedge clk);
        push <= 1'b0;
        while (sb.pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d input bytes giving %0d result words: %0d entries, %0d errors, %0d objects",
                 bytes_sent, sb.words_checked, sb.entries_checked, sb.errors_checked,
                 sb.objects_checked);
        $display("idle mixes: none, sender 74%%, receiver 74%%, both 26%%; %0d-cycle receiver hold-off",
                 HOLD_CYCLES);
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/tesp_pkg.sv
rtl/tesp_front.sv
rtl/tesp_queue.sv
rtl/tesp_back.sv
rtl/tree_entry_stream_parser.sv
rtl/tesp_checker.sv
bench/tb_tree_entry_stream_parser.sv
